>>> design/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared constants, codes and the paeth predictor for the png line unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package pngu_pkg;

  // line store and pixel geometry
  localparam int MAX_LINE_BYTES  = 8192;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int IDX_W  = $clog2(MAX_LINE_BYTES);
  localparam int POS_W  = IDX_W + 1;
  localparam int BSEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int PB_W = 4;
  localparam int LB_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES  = CFG_IDX_W'(1);

  // png filter types
  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  // work carried by the compute stage
  typedef enum logic [1:0] {
    OP_CLR  = 2'd0,
    OP_ERR  = 2'd1,
    OP_DATA = 2'd2
  } op_t;

  // paeth predictor on unsigned bytes
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/pngu_if.sv
// ----------------------------------------------------------------------------
// pngu channel interfaces
// Valid/ready channels for stream input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// filtered stream input
interface pngu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;
  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

// reconstructed byte output
interface pngu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       line_end;
  logic       bad_filter;
  modport source (output valid, output pixel_byte, output line_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input line_end, input bad_filter,
                  output ready);
endinterface

// register write channel
interface pngu_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/png_scanline_unfilter_core.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG scanline filter reconstruction with the previous line in a line store.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | transfer
//  in_s     | in  | data_byte[7:0], image_start           | valid && ready
//  out_m    | out | pixel_byte[7:0], line_end, bad_filter | valid && ready
//  cfg_s    | in  | index[3:0], data[15:0]                | valid && ready (ready=1)
//
// One byte per cycle when the output is not stalled; a data byte passes the
// compute stage (line store read at transfer) and then the output register.
// The left neighbour comes from the byte history updated as each byte leaves
// the compute stage, so a byte depends on the one just ahead of it.
// Reset is synchronous, active low; no clearing pass on the line store.
// A full output register stalls data bytes and error results; valid filter
// bytes pass through.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_core (
  input  wire logic clk,
  input  wire logic rst_n,
  pngu_in_if.sink   in_s,
  pngu_out_if.source out_m,
  pngu_cfg_if.sink  cfg_s
);
  import pngu_pkg::*;

  // configuration registers
  logic [PB_W-1:0] pixel_bytes_r;
  logic [LB_W-1:0] line_bytes_r;

  // line control
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       filter_r, filter_nxt;
  logic             first_row_r, first_row_nxt;
  logic             dropping_r, dropping_nxt;

  // compute stage
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [7:0]        s1_data_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [2:0]        s1_filter_r;
  logic [BSEL_W-1:0] s1_bsel_r;
  logic              s1_a_ok_r;
  logic              s1_c_ok_r;
  logic              s1_first_r;
  logic              s1_end_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_pixel_r;
  logic       out_end_r;
  logic       out_bad_r;

  // byte histories of the current and upper line
  logic [7:0] left_hist_r   [MAX_PIXEL_BYTES];
  logic [7:0] upleft_hist_r [MAX_PIXEL_BYTES];

  // line store
  logic [7:0] line_mem [MAX_LINE_BYTES];
  logic [7:0] mem_rdata_r;
  logic       mem_re;
  logic       mem_we;

  logic              in_xfer;
  logic              s1_adv;
  logic              s1_load;
  op_t               acc_op;
  logic              acc_start;
  logic              acc_drop;
  logic              acc_first;
  logic [POS_W-1:0]  acc_pos;
  logic [POS_W-1:0]  pos_m1;
  logic [IDX_W-1:0]  acc_idx;
  logic [PB_W-1:0]   bpp_eff;
  logic [LB_W-1:0]   lb_eff;
  logic              acc_end;
  logic              acc_a_ok;
  logic [7:0]        a_val, b_val, c_val;
  logic [8:0]        avg_sum;
  logic [7:0]        pred;
  logic [7:0]        val;

  // register writes are always taken
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r <= PB_W'(1);
      line_bytes_r  <= LB_W'(1);
    end else if (cfg_s.valid) begin
      if (cfg_s.index == CFG_PIXEL_BYTES) begin
        pixel_bytes_r <= cfg_s.data[PB_W-1:0];
      end else if (cfg_s.index == CFG_LINE_BYTES) begin
        line_bytes_r <= cfg_s.data[LB_W-1:0];
      end
    end
  end

  // effective geometry with out-of-range values clamped
  always_comb begin
    if (pixel_bytes_r == '0) begin
      bpp_eff = PB_W'(1);
    end else if (pixel_bytes_r > PB_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = PB_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = pixel_bytes_r;
    end
    if (line_bytes_r == '0) begin
      lb_eff = LB_W'(1);
    end else if (POS_W'(line_bytes_r) > POS_W'(MAX_LINE_BYTES)) begin
      lb_eff = LB_W'(MAX_LINE_BYTES);
    end else begin
      lb_eff = line_bytes_r;
    end
  end

  // handshake
  assign s1_adv  = s1_valid_r && ((s1_op_r == OP_CLR) || !out_valid_r || out_m.ready);
  assign in_s.ready = !s1_valid_r || s1_adv;
  assign in_xfer = in_s.valid && in_s.ready;

  // classify the incoming byte and advance line control
  always_comb begin
    acc_start = in_s.image_start;
    acc_drop  = acc_start ? 1'b0 : dropping_r;
    acc_first = acc_start ? 1'b1 : first_row_r;
    acc_pos   = acc_start ? '0 : pos_r;
    pos_m1    = acc_pos - POS_W'(1);
    acc_idx   = (pos_m1 >= POS_W'(MAX_LINE_BYTES)) ? IDX_W'(MAX_LINE_BYTES - 1)
                                                   : pos_m1[IDX_W-1:0];
    acc_end   = (acc_pos >= POS_W'(lb_eff));
    acc_a_ok  = (POS_W'(acc_idx) >= POS_W'(bpp_eff));
    acc_op        = OP_CLR;
    s1_load       = 1'b0;
    pos_nxt       = pos_r;
    filter_nxt    = filter_r;
    first_row_nxt = first_row_r;
    dropping_nxt  = dropping_r;
    if (in_xfer) begin
      pos_nxt       = acc_pos;
      first_row_nxt = acc_first;
      dropping_nxt  = acc_drop;
      if (!acc_drop) begin
        s1_load = 1'b1;
        if (acc_pos == '0) begin
          if (in_s.data_byte > 8'(FLT_PAETH)) begin
            acc_op       = OP_ERR;
            dropping_nxt = 1'b1;
          end else begin
            acc_op     = OP_CLR;
            filter_nxt = in_s.data_byte[2:0];
            pos_nxt    = POS_W'(1);
          end
        end else begin
          acc_op = OP_DATA;
          if (acc_end) begin
            pos_nxt       = '0;
            first_row_nxt = 1'b0;
          end else begin
            pos_nxt = acc_pos + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      filter_r    <= FLT_NONE;
      first_row_r <= 1'b1;
      dropping_r  <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      filter_r    <= filter_nxt;
      first_row_r <= first_row_nxt;
      dropping_r  <= dropping_nxt;
    end
  end

  // compute stage load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r     <= acc_op;
      s1_data_r   <= in_s.data_byte;
      s1_idx_r    <= acc_idx;
      s1_filter_r <= filter_r;
      s1_bsel_r   <= BSEL_W'(bpp_eff - PB_W'(1));
      s1_a_ok_r   <= acc_a_ok;
      s1_c_ok_r   <= acc_a_ok && !acc_first;
      s1_first_r  <= acc_first;
      s1_end_r    <= acc_end;
    end
  end

  // line store: read at transfer, write as the byte leaves the compute stage
  assign mem_re = s1_load && (acc_op == OP_DATA) && !acc_first;
  assign mem_we = s1_adv && (s1_op_r == OP_DATA);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_idx_r] <= val;
    end
    if (mem_re) begin
      mem_rdata_r <= line_mem[acc_idx];
    end
  end

  // neighbours and predictor
  always_comb begin
    b_val   = s1_first_r ? 8'd0 : mem_rdata_r;
    a_val   = s1_a_ok_r ? left_hist_r[s1_bsel_r] : 8'd0;
    c_val   = s1_c_ok_r ? upleft_hist_r[s1_bsel_r] : 8'd0;
    avg_sum = {1'b0, a_val} + {1'b0, b_val};
    case (s1_filter_r)
      FLT_SUB:   pred = a_val;
      FLT_UP:    pred = b_val;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: pred = paeth(a_val, b_val, c_val);
      default:   pred = 8'd0;
    endcase
    val = s1_data_r + pred;
  end

  // histories: cleared by a filter byte, shifted by a data byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist_r[k]   <= 8'd0;
        upleft_hist_r[k] <= 8'd0;
      end
    end else if (s1_adv) begin
      if (s1_op_r == OP_CLR) begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_hist_r[k]   <= 8'd0;
          upleft_hist_r[k] <= 8'd0;
        end
      end else if (s1_op_r == OP_DATA) begin
        for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
          left_hist_r[k]   <= left_hist_r[k-1];
          upleft_hist_r[k] <= upleft_hist_r[k-1];
        end
        left_hist_r[0]   <= val;
        upleft_hist_r[0] <= b_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && (s1_op_r != OP_CLR)) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_op_r != OP_CLR)) begin
      if (s1_op_r == OP_ERR) begin
        out_pixel_r <= 8'd0;
        out_end_r   <= 1'b0;
        out_bad_r   <= 1'b1;
      end else begin
        out_pixel_r <= val;
        out_end_r   <= s1_end_r;
        out_bad_r   <= 1'b0;
      end
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.pixel_byte = out_pixel_r;
  assign out_m.line_end   = out_end_r;
  assign out_m.bad_filter = out_bad_r;

`ifndef SYNTH
  // a line store entry is never written and read in the same cycle
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (s1_idx_r == acc_idx)))
    else $error("line store read and write collide");

  // an error result carries no byte and no line end
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_pixel_r == 8'd0 && !out_end_r))
    else $error("error result with payload");

  // a pending error always has the drop state behind it
  a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_op_r == OP_ERR) |-> dropping_r)
    else $error("error in flight without drop state");

  // the last byte of a line returns to waiting for a filter byte
  a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_load && acc_op == OP_DATA && acc_end) |=> (pos_r == '0 && !first_row_r))
    else $error("line end did not wrap position");
`endif

endmodule

`default_nettype wire

>>> bench/png_unfilter_checker.sv
// ----------------------------------------------------------------------------
// png_unfilter_checker
// Watches the stream, result and register channels of the png line unfilter,
// rebuilds every scanline byte on its own and compares each result transfer
// with the oldest expected byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module png_unfilter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_image_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_pixel_byte,
  input  logic        out_line_end,
  input  logic        out_bad_filter,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fail_count,
  output int          checked_count,
  output int          bad_filter_count
);
  import pngu_pkg::*;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       line_end;
    logic       bad_filter;
  } recon_t;

  // register copies
  logic [PB_W-1:0] pix_bytes_reg;
  logic [LB_W-1:0] line_bytes_reg;

  // unfilter state
  logic [7:0]  prev_line [MAX_LINE_BYTES];
  logic [7:0]  left_bytes [MAX_PIXEL_BYTES];
  logic [7:0]  upleft_bytes [MAX_PIXEL_BYTES];
  int unsigned line_pos;
  logic [2:0]  cur_filter;
  bit          first_line;
  bit          skip_image;

  recon_t expected_bytes[$];

  // paeth choice between left, above and upper-left
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int da;
    int db;
    int dc;
    da = int'(b) - int'(c);
    db = int'(a) - int'(c);
    dc = int'(a) + int'(b) - 2 * int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // rebuild one stream byte, queue the byte it gives if any
  task automatic unfilter_byte(input logic [7:0] d, input logic st);
    int unsigned bpp;
    int unsigned lb;
    int unsigned idx;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    logic [7:0]  val;
    recon_t      r;
    if (st) begin
      skip_image = 1'b0;
      first_line = 1'b1;
      line_pos = 0;
    end
    if (skip_image) return;

    // filter type byte opens the line
    if (line_pos == 0) begin
      if (d > 8'(FLT_PAETH)) begin
        skip_image = 1'b1;
        r = '{pixel_byte: 8'd0, line_end: 1'b0, bad_filter: 1'b1};
        expected_bytes.push_back(r);
        return;
      end
      cur_filter = d[2:0];
      foreach (left_bytes[k]) begin
        left_bytes[k] = 8'd0;
        upleft_bytes[k] = 8'd0;
      end
      line_pos = 1;
      return;
    end

    bpp = (pix_bytes_reg == 0) ? 1 :
          (pix_bytes_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : pix_bytes_reg;
    lb = (line_bytes_reg == 0) ? 1 :
         (line_bytes_reg > MAX_LINE_BYTES) ? MAX_LINE_BYTES : line_bytes_reg;
    idx = line_pos - 1;
    if (idx >= MAX_LINE_BYTES) idx = MAX_LINE_BYTES - 1;

    // neighbours, zero off the left edge and on an image's first line
    b = first_line ? 8'd0 : prev_line[idx];
    a = (idx >= bpp) ? left_bytes[bpp-1] : 8'd0;
    c = (idx >= bpp && !first_line) ? upleft_bytes[bpp-1] : 8'd0;

    case (cur_filter)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
      FLT_PAETH: pred = paeth_pick(a, b, c);
      default:   pred = 8'd0;
    endcase
    val = d + pred;

    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_bytes[k] = left_bytes[k-1];
      upleft_bytes[k] = upleft_bytes[k-1];
    end
    left_bytes[0] = val;
    upleft_bytes[0] = b;
    prev_line[idx] = val;

    r.pixel_byte = val;
    r.bad_filter = 1'b0;
    if (idx + 1 >= lb) begin
      r.line_end = 1'b1;
      line_pos = 0;
      first_line = 1'b0;
    end else begin
      r.line_end = 1'b0;
      line_pos = line_pos + 1;
    end
    expected_bytes.push_back(r);
  endtask

  // compare results first, then take register writes and stream bytes
  always @(posedge clk) begin : watch
    recon_t want;
    if (!rst_n) begin
      pix_bytes_reg = PB_W'(1);
      line_bytes_reg = LB_W'(1);
      foreach (left_bytes[k]) begin
        left_bytes[k] = 8'd0;
        upleft_bytes[k] = 8'd0;
      end
      line_pos = 0;
      cur_filter = FLT_NONE;
      first_line = 1'b1;
      skip_image = 1'b0;
      fail_count = 0;
      checked_count = 0;
      bad_filter_count = 0;
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("result transfer with nothing expected: %s %0h line_end %0b bad_filter %0b",
                 "pixel_byte", out_pixel_byte, out_line_end, out_bad_filter);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          checked_count++;
          if (want.bad_filter) bad_filter_count++;
          if (out_pixel_byte !== want.pixel_byte) begin
            $error("pixel_byte: expected %0h, got %0h", want.pixel_byte, out_pixel_byte);
            fail_count++;
          end
          if (out_line_end !== want.line_end) begin
            $error("line_end: expected %0b, got %0b", want.line_end, out_line_end);
            fail_count++;
          end
          if (out_bad_filter !== want.bad_filter) begin
            $error("bad_filter: expected %0b, got %0b", want.bad_filter, out_bad_filter);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PIXEL_BYTES: pix_bytes_reg = cfg_data[PB_W-1:0];
          CFG_LINE_BYTES:  line_bytes_reg = cfg_data[LB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) unfilter_byte(in_data_byte, in_image_start);
    end
    pending <= expected_bytes.size();
  end

endmodule

>>> bench/tb_png_scanline_unfilter_core.sv
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter_core
// Drives filtered png streams into the line unfilter: directed lines for every
// filter type, edge cases and a long line, then random images under
// several register settings and idle patterns. The checker does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_png_scanline_unfilter_core;
  import pngu_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(15);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int line_len = 1;
  int sent_bytes = 0;
  int dropped_bytes = 0;
  int settings_count = 0;

  int pending;
  int fail_count;
  int checked_count;
  int bad_filter_count;

  logic [2:0] filter_codes [5] = '{FLT_NONE, FLT_SUB, FLT_UP, FLT_AVG, FLT_PAETH};

  pngu_in_if  in_ch ();
  pngu_out_if out_ch ();
  pngu_cfg_if cfg_ch ();

  png_scanline_unfilter_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch),
    .cfg_s (cfg_ch)
  );

  png_unfilter_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_image_start   (in_ch.image_start),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_pixel_byte   (out_ch.pixel_byte),
    .out_line_end     (out_ch.line_end),
    .out_bad_filter   (out_ch.bad_filter),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .pending          (pending),
    .fail_count       (fail_count),
    .checked_count    (checked_count),
    .bad_filter_count (bad_filter_count)
  );

  always #5 clk = ~clk;

  // receiver side, random back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // data with the byte extremes showing up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one stream transfer; valid stays up when the next byte follows at once
  task automatic send_byte(input logic [7:0] d, input logic st);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.image_start <= st;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
  endtask

  // filter byte, then n data bytes
  task automatic send_line(input logic [2:0] filt, input logic st, input int n);
    send_byte({5'd0, filt}, st);
    repeat (n) send_byte(pick_byte(), 1'b0);
  endtask

  // stop sending until every expected byte is out and the pipe is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // register write, valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_LINE_BYTES) begin
      line_len = (val[LB_W-1:0] == 0) ? 1 :
                 (val[LB_W-1:0] > MAX_LINE_BYTES) ? MAX_LINE_BYTES : int'(val[LB_W-1:0]);
    end
  endtask

  task automatic write_cfg(input logic [15:0] pb, input logic [15:0] lb);
    write_reg(CFG_PIXEL_BYTES, pb);
    write_reg(CFG_LINE_BYTES, lb);
    cfg_ch.valid <= 1'b0;
    settings_count++;
  endtask

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin idle_pct = 59; stall_pct = 0;  end
      IDLE_RECV: begin idle_pct = 0;  stall_pct = 59; end
      default:   begin idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // random image: mostly whole lines, some bad filters and cut lines
  task automatic send_image();
    int nlines;
    int r;
    nlines = $urandom_range(1, 6);
    for (int l = 0; l < nlines; l++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        // bad filter type, the rest of the image is ignored
        send_byte(8'($urandom_range(int'(FLT_PAETH) + 1, 255)), l == 0);
        repeat ($urandom_range(0, 4)) begin
          send_byte(pick_byte(), 1'b0);
          dropped_bytes++;
        end
        return;
      end
      if (r < 9) begin
        // line cut short, the next image start abandons it
        send_line(filter_codes[$urandom_range(4)], l == 0, $urandom_range(0, line_len - 1));
        return;
      end
      send_line(filter_codes[$urandom_range(4)], l == 0, line_len);
    end
  endtask

  // stimulus
  initial begin
    int target;
    int wait_cycles;
    logic [15:0] lb;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.image_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_PIXEL_BYTES;
    cfg_ch.data = 16'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every filter type over a small image
    write_cfg(16'd2, 16'd5);
    send_line(FLT_NONE, 1'b1, 5);
    send_line(FLT_SUB, 1'b0, 5);
    send_line(FLT_UP, 1'b0, 5);
    send_line(FLT_AVG, 1'b0, 5);
    send_line(FLT_PAETH, 1'b0, 5);

    // bad filter, ignored bytes, bad filter on an image start
    send_byte(8'(int'(FLT_PAETH) + 1), 1'b0);
    send_byte(8'({5'd0, FLT_NONE}), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);

    // image start in the middle of a line
    send_line(FLT_SUB, 1'b1, 2);
    send_line(FLT_UP, 1'b1, 5);
    send_line(FLT_PAETH, 1'b0, 5);

    // zero pixel size, then line length cut below the position mid-line
    drain();
    write_cfg(16'd0, 16'd6);
    send_line(FLT_SUB, 1'b1, 4);
    drain();
    write_reg(CFG_LINE_BYTES, 16'd2);
    cfg_ch.valid <= 1'b0;
    send_byte(pick_byte(), 1'b0);
    send_line(FLT_PAETH, 1'b0, 2);

    // pixel size above range, zero line length, write to an unused index
    drain();
    write_reg(CFG_UNUSED, 16'($urandom));
    write_cfg(16'd15, 16'd0);
    send_line(FLT_AVG, 1'b1, 1);
    send_line(FLT_PAETH, 1'b0, 1);
    send_line(FLT_SUB, 1'b0, 1);
    send_line(FLT_NONE, 1'b0, 1);

    // long line, register bits above the field widths set
    drain();
    write_cfg(16'hFFF8, 16'hC0C8);
    send_line(FLT_SUB, 1'b1, line_len);
    send_line(FLT_PAETH, 1'b0, line_len);

    // random images under random settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(9))
        0:       lb = 16'd0;
        1:       lb = 16'($urandom_range(25, 120));
        default: lb = 16'($urandom_range(1, 24));
      endcase
      write_cfg(16'($urandom_range(0, 15)), lb);
      set_idling(idle_mode_t'(ph % 4));
      target = sent_bytes - dropped_bytes + 190;
      while (sent_bytes - dropped_bytes < target) begin
        send_image();
        if ($urandom_range(19) == 0) drain();
      end
    end

    // wind down
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < 100000);
    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d expected results never came out", pending);
    $display("%0d stream bytes sent under %0d register settings, all filter types, idle mixes",
             sent_bytes, settings_count);
    $display("%0d results checked, %0d of them bad filter errors",
             checked_count, bad_filter_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
